// ===== rtl/core/ens_pkg.sv =====
// ----------------------------------------------------------------------------
// ens_pkg
// Shared widths, limits, opcodes and controller/datapath interface structs
// for the energy normalize scaler.
// ----------------------------------------------------------------------------
package ens_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_BITS    = 56;
  localparam int TARGET_BITS = 24;
  localparam int GAIN_BITS   = 40;
  localparam int OUT_BITS    = 32;
  localparam int OP_BITS     = 2;

  // sample magnitude needs one extra bit for the most negative code
  localparam int MAG_BITS = SAMPLE_BITS + 1;
  localparam int SQ_BITS  = 2 * MAG_BITS;
  localparam int SUM_BITS = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;

  // square root, one result bit per step
  localparam int ROOT_BITS = (ACC_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int REMT_BITS = REM_BITS + 2;

  // restoring divide, one quotient bit per step
  localparam int NUM_BITS = TARGET_BITS + FRAC_BITS;
  localparam int QW_BITS  = (NUM_BITS > GAIN_BITS) ? NUM_BITS : GAIN_BITS;

  // two partial products for sample times gain
  localparam int GAIN_LO_BITS = GAIN_BITS / 2;
  localparam int GAIN_HI_BITS = GAIN_BITS - GAIN_LO_BITS;
  localparam int PLO_BITS     = MAG_BITS + GAIN_LO_BITS;
  localparam int PHI_BITS     = MAG_BITS + GAIN_HI_BITS;
  localparam int PROD_BITS    = MAG_BITS + GAIN_BITS;
  localparam int QX_BITS      = ((PROD_BITS - FRAC_BITS + 1) > (OUT_BITS + 1)) ?
                                (PROD_BITS - FRAC_BITS + 1) : (OUT_BITS + 1);

  localparam int STEP_MAX = (ROOT_BITS > NUM_BITS) ? ROOT_BITS : NUM_BITS;
  localparam int CNT_BITS = $clog2(STEP_MAX);

  localparam logic [ACC_BITS-1:0]  ACC_MAX     = '1;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX    = '1;
  localparam logic [OUT_BITS-1:0]  OUT_POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS:0]    OUT_NEG_MAG = {2'b01, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [OP_BITS-1:0] {
    OP_ACC     = 2'd0,
    OP_SCALE   = 2'd1,
    OP_RESTART = 2'd2
  } ens_op_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic load_sample;
    logic sqrt_init;
    logic sqrt_step;
    logic gain_zero;
    logic div_init;
    logic div_step;
    logic gain_set;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } ens_cmd_t;

  typedef struct packed {
    logic gain_ready;
    logic root_zero;
    logic out_free;
  } ens_stat_t;

endpackage

// ===== rtl/core/ens_ctrl.sv =====
// ----------------------------------------------------------------------------
// ens_ctrl
// Sequencer: decodes input words and steps the datapath through square
// root, divide, multiply and output load.
// ----------------------------------------------------------------------------
module ens_ctrl
  import ens_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [OP_BITS-1:0] in_opcode,
  output logic               in_ready,
  input  ens_stat_t          stat,
  output ens_cmd_t           cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQRT   = 8'b0000_0010,
    ST_CHK    = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_SET    = 8'b0001_0000,
    ST_MUL_LO = 8'b0010_0000,
    ST_MUL_HI = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } ens_state_t;

  ens_state_t          state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_ACC:     cmd.acc = 1'b1;
            OP_RESTART: cmd.clr = 1'b1;
            OP_SCALE: begin
              cmd.load_sample = 1'b1;
              if (stat.gain_ready) begin
                state_nxt = ST_MUL_LO;
              end else begin
                cmd.sqrt_init = 1'b1;
                cnt_nxt       = '0;
                state_nxt     = ST_SQRT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = CNT_BITS'(cnt_r + 1'b1);
        if (cnt_r == CNT_BITS'(ROOT_BITS - 1)) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        // zero energy skips the divide
        if (stat.root_zero) begin
          cmd.gain_zero = 1'b1;
          state_nxt     = ST_MUL_LO;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = CNT_BITS'(cnt_r + 1'b1);
        if (cnt_r == CNT_BITS'(NUM_BITS - 1)) begin
          state_nxt = ST_SET;
        end
      end
      ST_SET: begin
        cmd.gain_set = 1'b1;
        state_nxt    = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fast_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_opcode == OP_SCALE && stat.gain_ready)
      |=> (state_r == ST_MUL_LO))
    else $error("scale with ready gain did not go straight to multiply");

  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |-> ($past(state_r) == ST_SQRT &&
      $past(cnt_r) == CNT_BITS'(ROOT_BITS - 1)))
    else $error("square root left before its last step");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SET) |-> ($past(state_r) == ST_DIV &&
      $past(cnt_r) == CNT_BITS'(NUM_BITS - 1)))
    else $error("divide left before its last step");
`endif

endmodule

// ===== rtl/core/ens_datapath.sv =====
// ----------------------------------------------------------------------------
// ens_datapath
// Energy accumulator, bit-serial square root and divider for the gain,
// split sample-times-gain multiply, rounding/saturation and output register.
// ----------------------------------------------------------------------------
module ens_datapath
  import ens_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                       cfg_wr_en,
  input  logic [TARGET_BITS-1:0]     cfg_wr_data,
  input  ens_cmd_t                   cmd,
  output ens_stat_t                  stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_scaled_sample,
  output logic                       out_saturated,
  output logic                       out_zero_energy
);

  // control registers
  logic [TARGET_BITS-1:0] target_r, target_nxt;
  logic [ACC_BITS-1:0]    energy_r, energy_nxt;
  logic [GAIN_BITS-1:0]   gain_r, gain_nxt;
  logic                   gain_ready_r, gain_ready_nxt;
  logic                   ewz_r, ewz_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // working registers
  logic [MAG_BITS-1:0]    mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [RAD_BITS-1:0]    rad_r, rad_nxt;
  logic [REM_BITS-1:0]    rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]   root_r, root_nxt;
  logic [ROOT_BITS-1:0]   drem_r, drem_nxt;
  logic [NUM_BITS-1:0]    quot_r, quot_nxt;
  logic [PLO_BITS-1:0]    plo_r, plo_nxt;
  logic [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic signed [OUT_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                   out_sat_r, out_sat_nxt;
  logic                   out_zero_r, out_zero_nxt;

  // sample magnitude and square
  logic                   in_neg;
  logic [MAG_BITS-1:0]    in_ext, in_mag;
  logic [SQ_BITS-1:0]     acc_sq;
  logic [SUM_BITS-1:0]    acc_sum;

  // square root step
  logic [REMT_BITS-1:0]   sq_rem_t, sq_trial;
  logic                   sq_ge;

  // divide step
  logic [ROOT_BITS:0]     dv_rem_t, dv_diff;
  logic                   dv_ge;
  logic [QW_BITS-1:0]     quot_ext;

  // multiply and result
  logic [PHI_BITS-1:0]    mul_hi;
  logic                   frac_nz;
  logic [QX_BITS-1:0]     qx;
  logic [OUT_BITS:0]      neg_mag;
  logic                   res_sat;
  logic [OUT_BITS-1:0]    res_val;

  assign in_neg  = in_sample[SAMPLE_BITS-1];
  assign in_ext  = {in_sample[SAMPLE_BITS-1], in_sample};
  assign in_mag  = in_neg ? MAG_BITS'(~in_ext + 1'b1) : in_ext;
  assign acc_sq  = SQ_BITS'(in_mag) * SQ_BITS'(in_mag);
  assign acc_sum = SUM_BITS'(energy_r) + SUM_BITS'(acc_sq);

  assign sq_rem_t = {rem_r, rad_r[RAD_BITS-1 -: 2]};
  assign sq_trial = REMT_BITS'({root_r, 2'b01});
  assign sq_ge    = (sq_rem_t >= sq_trial);

  assign dv_rem_t = {drem_r, quot_r[NUM_BITS-1]};
  assign dv_diff  = dv_rem_t - {1'b0, root_r};
  assign dv_ge    = (dv_rem_t >= {1'b0, root_r});
  assign quot_ext = QW_BITS'(quot_r);

  assign mul_hi = PHI_BITS'(mag_r) * PHI_BITS'(gain_r[GAIN_BITS-1:GAIN_LO_BITS]);

  // floor for positive, ceiling of magnitude for negative
  assign frac_nz = |prod_r[FRAC_BITS-1:0];
  assign qx      = QX_BITS'(prod_r[PROD_BITS-1:FRAC_BITS]) + QX_BITS'(neg_r & frac_nz);

  always_comb begin
    neg_mag = '0;
    if (!neg_r) begin
      res_sat = (qx > QX_BITS'(OUT_POS_MAX));
      res_val = res_sat ? OUT_POS_MAX : qx[OUT_BITS-1:0];
    end else begin
      res_sat = (qx > QX_BITS'(OUT_NEG_MAG));
      neg_mag = res_sat ? OUT_NEG_MAG : qx[OUT_BITS:0];
      res_val = OUT_BITS'(~neg_mag + 1'b1);
    end
  end

  always_comb begin
    target_nxt     = cfg_wr_en ? cfg_wr_data : target_r;
    energy_nxt     = energy_r;
    gain_nxt       = gain_r;
    gain_ready_nxt = gain_ready_r;
    ewz_nxt        = ewz_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    rad_nxt        = rad_r;
    rem_nxt        = rem_r;
    root_nxt       = root_r;
    drem_nxt       = drem_r;
    quot_nxt       = quot_r;
    plo_nxt        = plo_r;
    prod_nxt       = prod_r;
    out_sample_nxt = out_sample_r;
    out_sat_nxt    = out_sat_r;
    out_zero_nxt   = out_zero_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.acc) begin
      // saturating sum of squares
      energy_nxt     = (acc_sum > SUM_BITS'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_BITS-1:0];
      gain_ready_nxt = 1'b0;
    end
    if (cmd.clr) begin
      energy_nxt     = '0;
      gain_nxt       = '0;
      gain_ready_nxt = 1'b0;
      ewz_nxt        = 1'b0;
    end
    if (cmd.load_sample) begin
      mag_nxt = in_mag;
      neg_nxt = in_neg;
    end
    if (cmd.sqrt_init) begin
      rad_nxt  = RAD_BITS'(energy_r);
      rem_nxt  = '0;
      root_nxt = '0;
    end
    if (cmd.sqrt_step) begin
      rad_nxt  = {rad_r[RAD_BITS-3:0], 2'b00};
      rem_nxt  = sq_ge ? REM_BITS'(sq_rem_t - sq_trial) : REM_BITS'(sq_rem_t);
      root_nxt = {root_r[ROOT_BITS-2:0], sq_ge};
    end
    if (cmd.gain_zero) begin
      gain_nxt       = '0;
      ewz_nxt        = 1'b1;
      gain_ready_nxt = 1'b1;
    end
    if (cmd.div_init) begin
      quot_nxt = {target_r, {FRAC_BITS{1'b0}}};
      drem_nxt = '0;
    end
    if (cmd.div_step) begin
      drem_nxt = dv_ge ? dv_diff[ROOT_BITS-1:0] : dv_rem_t[ROOT_BITS-1:0];
      quot_nxt = {quot_r[NUM_BITS-2:0], dv_ge};
    end
    if (cmd.gain_set) begin
      gain_nxt       = (quot_ext > QW_BITS'(GAIN_MAX)) ? GAIN_MAX : quot_ext[GAIN_BITS-1:0];
      ewz_nxt        = 1'b0;
      gain_ready_nxt = 1'b1;
    end
    if (cmd.mul_lo) begin
      plo_nxt = PLO_BITS'(mag_r) * PLO_BITS'(gain_r[GAIN_LO_BITS-1:0]);
    end
    if (cmd.mul_hi) begin
      prod_nxt = (PROD_BITS'(mul_hi) << GAIN_LO_BITS) + PROD_BITS'(plo_r);
    end
    if (cmd.load_out) begin
      out_sample_nxt = res_val;
      out_sat_nxt    = res_sat;
      out_zero_nxt   = ewz_r;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      energy_r     <= '0;
      gain_r       <= '0;
      gain_ready_r <= 1'b0;
      ewz_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      target_r     <= target_nxt;
      energy_r     <= energy_nxt;
      gain_r       <= gain_nxt;
      gain_ready_r <= gain_ready_nxt;
      ewz_r        <= ewz_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    rad_r        <= rad_nxt;
    rem_r        <= rem_nxt;
    root_r       <= root_nxt;
    drem_r       <= drem_nxt;
    quot_r       <= quot_nxt;
    plo_r        <= plo_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
    out_sat_r    <= out_sat_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign stat.gain_ready = gain_ready_r;
  assign stat.root_zero  = (root_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_scaled_sample = out_sample_r;
  assign out_saturated     = out_sat_r;
  assign out_zero_energy   = out_zero_r;

`ifndef SYNTHESIS
  a_energy_grows: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr |=> (energy_r >= $past(energy_r)))
    else $error("energy dropped without a restart");

  a_zero_gain_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_sample_r == '0 && !out_sat_r))
    else $error("nonzero word with zero energy flag");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while held");
`endif

endmodule

// ===== rtl/core/energy_normalize_scaler.sv =====
// ----------------------------------------------------------------------------
// energy_normalize_scaler
// Two-pass L2 normalization: sum of squares, then samples times a gain.
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_opcode / in_sample words under in_valid / in_ready
//                 accumulate adds sample squared to the energy, restart clears
//                 it, scale gives one out word; code three is dropped
//   out channel : out_scaled_sample, out_saturated, out_zero_energy under
//                 out_valid / out_ready, held in an output register
//   cfg port    : cfg_wr_en / cfg_wr_data set the target root energy, write
//                 only while idle
//   timing      : accumulate and restart act in the idle state; a scale word with
//                 the gain already known goes through two partial products
//                 then rounding/saturation into the output register
//   gain        : the first scale word after new energy first runs 28 square
//                 root steps and 40 divide steps, one bit a cycle, plus the
//                 check and gain-set states; with zero energy the divide is
//                 skipped along with the gain-set state
//   reset       : rst_n low clears energy, gain, target and the output valid flag
//   stall       : a new word is taken while a result waits; a scale word then
//                 holds in the load cycle until out_ready frees the register
// ----------------------------------------------------------------------------
module energy_normalize_scaler
  import ens_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_BITS-1:0]            in_opcode,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_BITS-1:0]    out_scaled_sample,
  output logic                          out_saturated,
  output logic                          out_zero_energy,
  input  logic                          cfg_wr_en,
  input  logic [TARGET_BITS-1:0]        cfg_wr_data
);

  ens_cmd_t  cmd;
  ens_stat_t stat;

  ens_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ens_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_sample         (in_sample),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scaled_sample (out_scaled_sample),
    .out_saturated     (out_saturated),
    .out_zero_energy   (out_zero_energy)
  );

endmodule

// ===== tb/energy_normalize_scaler_check.sv =====
// ----------------------------------------------------------------------------
// energy_normalize_scaler_check
// Watches the in, out and cfg ports of the scaler. It keeps its own copy of the
// energy, gain and target and works out each scaled word when a scale word is
// taken. Each out word is compared field by field with the oldest expected
// word. The failure count, the number of words still expected and the number
// of words checked go back to the test top.
// ----------------------------------------------------------------------------
module energy_normalize_scaler_check
  import ens_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [OP_BITS-1:0]            in_opcode,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [OUT_BITS-1:0]    out_scaled_sample,
  input  logic                          out_saturated,
  input  logic                          out_zero_energy,
  input  logic                          cfg_wr_en,
  input  logic [TARGET_BITS-1:0]        cfg_wr_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);

  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       sat;
    logic                       zero;
  } scaled_word_t;

  logic [TARGET_BITS-1:0] target_root;
  logic [ACC_BITS-1:0]    energy;
  logic [GAIN_BITS-1:0]   gain;
  logic                   gain_known;
  logic                   energy_zero;
  scaled_word_t           expected_words[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic logic [MAG_BITS-1:0] magnitude(logic signed [SAMPLE_BITS-1:0] s);
    if (s[SAMPLE_BITS-1])
      return (MAG_BITS'(1) << SAMPLE_BITS) - MAG_BITS'(unsigned'(s));
    return MAG_BITS'(unsigned'(s));
  endfunction

  // floor square root, built one bit at a time from the top
  function automatic logic [ROOT_BITS-1:0] floor_root(logic [ACC_BITS-1:0] v);
    logic [63:0]          trial;
    logic [ROOT_BITS-1:0] r;
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = 64'(r) | (64'd1 << b);
      if (trial * trial <= 64'(v))
        r = trial[ROOT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic scaled_word_t scale_word(logic signed [SAMPLE_BITS-1:0] s);
    logic [MAG_BITS-1:0] mag;
    logic [63:0]         root_v;
    logic [63:0]         quot;
    logic [63:0]         prod;
    logic [63:0]         q;
    scaled_word_t        w;
    mag = magnitude(s);
    // gain is worked out lazily, on the first scale word after new energy
    if (!gain_known) begin
      root_v = 64'(floor_root(energy));
      if (root_v == 0) begin
        gain        = '0;
        energy_zero = 1'b1;
      end else begin
        quot        = (64'(target_root) << FRAC_BITS) / root_v;
        gain        = (quot > 64'(GAIN_MAX)) ? GAIN_MAX : quot[GAIN_BITS-1:0];
        energy_zero = 1'b0;
      end
      gain_known = 1'b1;
    end
    prod  = 64'(mag) * 64'(gain);
    q     = prod >> FRAC_BITS;
    w.sat = 1'b0;
    if (!s[SAMPLE_BITS-1]) begin
      if (q > 64'(OUT_POS_MAX)) begin
        q     = 64'(OUT_POS_MAX);
        w.sat = 1'b1;
      end
    end else begin
      // negative side rounds toward minus infinity
      if (prod[FRAC_BITS-1:0] != '0)
        q = q + 64'd1;
      if (q > 64'(OUT_NEG_MAG)) begin
        q     = 64'(OUT_NEG_MAG);
        w.sat = 1'b1;
      end
      q = 64'd0 - q;
    end
    w.value = q[OUT_BITS-1:0];
    w.zero  = energy_zero;
    return w;
  endfunction

  always @(posedge clk) begin
    scaled_word_t        want;
    logic [MAG_BITS-1:0] mag;
    logic [63:0]         sum;
    if (!rst_n) begin
      target_root = '0;
      energy      = '0;
      gain        = '0;
      gain_known  = 1'b0;
      energy_zero = 1'b0;
      expected_words.delete();
    end else begin
      // out side first: a word taken at this edge cannot be the one leaving
      if (out_valid && out_ready) begin
        checked++;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected out word %0d: value %0d sat %0b zero %0b",
                     checked, out_scaled_sample, out_saturated, out_zero_energy);
        end else begin
          want = expected_words.pop_front();
          if (out_scaled_sample !== want.value || out_saturated !== want.sat ||
              out_zero_energy !== want.zero) begin
            fail_count++;
            if (fail_count <= 10)
              $display("out word %0d: expected %0d sat %0b zero %0b, got %0d sat %0b zero %0b",
                       checked, want.value, want.sat, want.zero,
                       out_scaled_sample, out_saturated, out_zero_energy);
          end
        end
      end
      if (cfg_wr_en)
        target_root = cfg_wr_data;
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_ACC: begin
            mag = magnitude(in_sample);
            sum = 64'(energy) + 64'(mag) * 64'(mag);
            energy     = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_BITS-1:0];
            gain_known = 1'b0;
          end
          OP_SCALE: begin
            expected_words.push_back(scale_word(in_sample));
          end
          OP_RESTART: begin
            energy      = '0;
            gain        = '0;
            gain_known  = 1'b0;
            energy_zero = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== tb/energy_normalize_scaler_test.sv =====
// ----------------------------------------------------------------------------
// energy_normalize_scaler_test
// Drives the scaler with a short directed set of edge cases, then random
// accumulate/scale sequences under several target settings, with random
// gaps and stalls on both channels. The checker beside the block predicts
// and compares every out word; this top gives the verdict.
// ----------------------------------------------------------------------------
module energy_normalize_scaler_test;
  import ens_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS  = 1000;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [OP_BITS-1:0]            in_opcode;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [OUT_BITS-1:0]    out_scaled_sample;
  logic                          out_saturated;
  logic                          out_zero_energy;
  logic                          cfg_wr_en;
  logic [TARGET_BITS-1:0]        cfg_wr_data;

  int fail_count;
  int pending;
  int checked;
  int words_sent;
  int scale_sent;
  int cfg_writes;
  int send_burst;
  int recv_burst;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  energy_normalize_scaler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scaled_sample (out_scaled_sample),
    .out_saturated     (out_saturated),
    .out_zero_energy   (out_zero_energy),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  energy_normalize_scaler_check result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scaled_sample (out_scaled_sample),
    .out_saturated     (out_saturated),
    .out_zero_energy   (out_zero_energy),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  // mostly random waits, now and then a run of back-to-back words
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int kind);
    case (kind)
      0: return SAMPLE_BITS'($urandom);
      1: return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd0;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic send_word(input logic [OP_BITS-1:0] op,
                           input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = draw_gap(send_burst);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (op != OP_UNUSED)
      words_sent++;
    if (op == OP_SCALE)
      scale_sent++;
  endtask

  // stop sending, let every expected word out, then cover the gain latency
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_target(input logic [TARGET_BITS-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  task automatic run_phase(input int quota, input bit pause_midway);
    int start;
    int kind;
    start = words_sent;
    while (words_sent - start < quota) begin
      if (pause_midway && words_sent - start >= quota / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
      kind = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 85) begin
        // well-formed pass: energy first, then scale words
        if ($urandom_range(0, 3) != 0)
          send_word(OP_RESTART, pick_sample(0));
        repeat ($urandom_range(1, 16)) send_word(OP_ACC, pick_sample(kind));
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 9) == 0)
            send_word(OP_ACC, pick_sample(kind));
          send_word(OP_SCALE, pick_sample($urandom_range(0, 2)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(OP_BITS'($urandom_range(0, 3)), pick_sample(kind));
      end
    end
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = draw_gap(recv_burst);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
    $display("energy_normalize_scaler_test failed");
    $finish;
  end

  initial begin
    logic [TARGET_BITS-1:0] tgt;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_opcode   = OP_ACC;
    in_sample   = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    words_sent  = 0;
    scale_sent  = 0;
    cfg_writes  = 0;
    send_burst  = 0;
    recv_burst  = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // target still at its reset value of zero
    send_word(OP_SCALE, 16'sh7FFF);      // scale before any energy
    send_word(OP_ACC, 16'sh8000);
    send_word(OP_SCALE, 16'sh8000);      // nonzero energy, zero gain
    send_word(OP_UNUSED, 16'sh8000);     // dropped

    drain_results();
    write_target('1);
    send_word(OP_RESTART, 16'sh7FFF);
    send_word(OP_ACC, 16'sd1);           // tiny energy, huge gain
    send_word(OP_SCALE, 16'sh7FFF);
    send_word(OP_SCALE, 16'sh8000);
    send_word(OP_SCALE, 16'sd0);
    send_word(OP_SCALE, -16'sd1);
    send_word(OP_SCALE, 16'sd1);
    send_word(OP_ACC, 16'sh8000);        // more energy after scaling
    send_word(OP_SCALE, 16'sd12345);
    send_word(OP_RESTART, -16'sd1);
    send_word(OP_SCALE, -16'sd5);        // energy cleared
    send_word(OP_ACC, 16'sd0);
    send_word(OP_SCALE, 16'sd7);         // only zero samples summed

    drain_results();
    write_target(TARGET_BITS'(1));
    send_word(OP_RESTART, 16'sd0);
    send_word(OP_ACC, 16'sh8000);
    send_word(OP_ACC, 16'sh7FFF);
    send_word(OP_SCALE, 16'sh8000);
    send_word(OP_SCALE, 16'sh7FFF);
    send_word(OP_SCALE, -16'sd3);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       tgt = TARGET_BITS'($urandom);
        1:       tgt = '1;
        2:       tgt = TARGET_BITS'($urandom_range(0, 255));
        default: tgt = (p == PHASES - 1) ? '0 :
                       TARGET_BITS'($urandom_range(1 << 16, 1 << 20));
      endcase
      drain_results();
      write_target(tgt);
      run_phase(RANDOM_WORDS / PHASES, p == 2);
    end

    drain_results();
    $display("covered %0d words (%0d scale) across %0d target settings: edge cases, then random passes",
             words_sent, scale_sent, cfg_writes);
    $display("%0d out words checked, %0d failures, %0d words never arrived",
             checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("energy_normalize_scaler_test passed");
    end else begin
      $display("energy_normalize_scaler_test failed");
    end
    $finish;
  end

endmodule
